FILE: hdl/spq_pkg.sv
package spq_pkg;

  localparam int COORD_W    = 24;
  localparam int FRAC_W     = 12;
  localparam int RAD_W      = COORD_W - 1;
  localparam int TOL_W      = 12;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ROOT_W     = COORD_W + 2;
  localparam int SUM_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int PROD_W     = DIFF_W + RAD_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int QUO_W      = RAD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1) << FRAC_W;
  localparam logic [TOL_W-1:0] TOL_RESET    = TOL_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [RAD_W-1:0]          other_radius;
  } query_t;

  typedef struct packed {
    logic                      overlaps;
    logic                      outside;
    logic                      on_shell;
    logic                      degenerate;
    logic signed [COORD_W-1:0] closest_x;
    logic signed [COORD_W-1:0] closest_y;
    logic signed [COORD_W-1:0] closest_z;
  } result_t;

  // per-item data carried alongside the distance computation
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] mag;
    logic [2:0]             neg;
    logic [RAD_W-1:0]       orad;
    logic                   degen;
  } side_t;

  typedef struct packed {
    logic overlaps;
    logic outside;
    logic on_shell;
    logic degenerate;
  } flags_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  // one digit of the restoring square root
  function automatic sq_step_t sqrt_step(input logic [REM_W-1:0] rem,
                                         input logic [ROOT_W-1:0] root,
                                         input logic [1:0] pair);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sq_step_t         r;
    t     = {rem, pair};
    trial = (REM_W+2)'({root, 2'b01});
    if (t >= trial) begin
      r.rem  = REM_W'(t - trial);
      r.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(t);
      r.root = {root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // center plus signed offset, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] place_coord(
      input logic signed [COORD_W-1:0] c, input logic [QUO_W-1:0] q, input logic neg);
    logic signed [COORD_W+1:0] v;
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] lo;
    hi = (COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - (COORD_W+2)'(1);
    if (neg) begin
      v = (COORD_W+2)'(c) - $signed((COORD_W+2)'(q));
    end else begin
      v = (COORD_W+2)'(c) + $signed((COORD_W+2)'(q));
    end
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return COORD_W'(v);
  endfunction

endpackage

FILE: hdl/sphere_point_query_core.sv
// channel   dir  handshake                     word
// query     in   query_valid / query_stall     query_t: point x, y, z and other radius
// result    out  result_valid / result_stall   result_t: four flags, closest x, y, z
// cfg       in   cfg_valid / cfg_ready         cfg_index, cfg_data (register write)
//
// one query word per cycle while query_stall is low; 56 register stages from the
// edge that accepts the query up to and including result_valid
// the bulk is the 26-stage square root and the 23-stage divider, one bit per stage
// rst is synchronous and clears valid bits and config registers to their defaults
// a word arriving under result_stall is absorbed by a skid register; query_stall is that register's
// valid bit, so the pipeline freezes only once both output registers hold a word
module sphere_point_query_core import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  query_valid,
  output logic                  query_stall,
  input  query_t                query,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          radius;
  logic [TOL_W-1:0]          tolerance;

  // whole pipeline moves together, held only while the skid is full
  logic                      adv;

  logic                      f_valid;
  logic [SUM_W-1:0]          f_sum;
  side_t                     f_side;

  logic                      s_valid;
  logic [ROOT_W-1:0]         s_root;
  logic [REM_W-1:0]          s_rem;
  side_t                     s_side;

  logic                      d_valid;
  logic [2:0][QUO_W-1:0]     d_quo;
  logic [2:0]                d_neg;
  flags_t                    d_flags;

  // last pipeline stage, then output register and skid
  logic                      z_valid;
  result_t                   z_word;
  result_t                   z_next;
  logic                      skid_valid;
  result_t                   skid;

  assign cfg_ready   = 1'b1;
  assign adv         = !skid_valid;
  assign query_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
      radius    <= RADIUS_RESET;
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X:  center_x  <= cfg_data;
        CFG_CENTER_Y:  center_y  <= cfg_data;
        CFG_CENTER_Z:  center_z  <= cfg_data;
        CFG_RADIUS:    radius    <= cfg_data[RAD_W-1:0];
        CFG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets, squares, sum of squares
  spq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (query_valid && !query_stall),
    .query     (query),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .out_valid (f_valid),
    .sum       (f_sum),
    .side      (f_side)
  );

  // floor square root with final remainder
  spq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .sum       (f_sum),
    .in_side   (f_side),
    .out_valid (s_valid),
    .root      (s_root),
    .rem       (s_rem),
    .out_side  (s_side)
  );

  // rounding, flags, and |d| * radius / dist per axis
  spq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_valid),
    .root      (s_root),
    .rem       (s_rem),
    .side      (s_side),
    .radius    (radius),
    .tolerance (tolerance),
    .out_valid (d_valid),
    .quo       (d_quo),
    .neg       (d_neg),
    .flags     (d_flags)
  );

  // add the offset back to the center; a point at the center returns the center
  always_comb begin
    z_next.overlaps   = d_flags.overlaps;
    z_next.outside    = d_flags.outside;
    z_next.on_shell   = d_flags.on_shell;
    z_next.degenerate = d_flags.degenerate;
    if (d_flags.degenerate) begin
      z_next.closest_x = center_x;
      z_next.closest_y = center_y;
      z_next.closest_z = center_z;
    end else begin
      z_next.closest_x = place_coord(center_x, d_quo[0], d_neg[0]);
      z_next.closest_y = place_coord(center_y, d_quo[1], d_neg[1]);
      z_next.closest_z = place_coord(center_z, d_quo[2], d_neg[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z_valid <= 1'b0;
    end else if (adv) begin
      z_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_word <= z_next;
    end
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= z_valid;
      end
    end else if (z_valid && adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_valid ? skid : z_word;
    end else if (z_valid && adv) begin
      skid <= z_word;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a word while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result_stall |=> result_valid && !skid_valid)
    else $error("skid word not moved to the output register");

  a_center_not_outside: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> !result.outside)
    else $error("point at the center reported outside");
`endif

endmodule

FILE: hdl/spq_front.sv
module spq_front import spq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  query_t                    query,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  output logic                      out_valid,
  output logic [SUM_W-1:0]          sum,
  output side_t                     side
);

  logic                   v1;
  logic                   v2;
  logic [2:0][DIFF_W-1:0] d1;
  logic [RAD_W-1:0]       orad1;
  logic [2:0][SQ_W-1:0]   sq2;
  side_t                  side2;
  logic signed [SQ_W-1:0] sq_c [3];
  side_t                  side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // magnitudes, signs and exact squares of the offsets
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_c.neg[i] = d1[i][DIFF_W-1];
      side_c.mag[i] = d1[i][DIFF_W-1] ? -d1[i] : d1[i];
      sq_c[i]       = $signed(d1[i]) * $signed(d1[i]);
    end
    side_c.orad  = orad1;
    side_c.degen = (d1 == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DIFF_W'(query.point_x) - DIFF_W'(center_x);
      d1[1] <= DIFF_W'(query.point_y) - DIFF_W'(center_y);
      d1[2] <= DIFF_W'(query.point_z) - DIFF_W'(center_z);
      orad1 <= query.other_radius;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= sq_c[i];
      end
      side2 <= side_c;
      sum   <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      side  <= side2;
    end
  end

endmodule

FILE: hdl/spq_sqrt.sv
module spq_sqrt import spq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [REM_W-1:0]  rem,
  output side_t             out_side
);

  logic [ROOT_W:1]   v_r;
  logic [SUM_W-1:0]  n_r    [1:ROOT_W];
  logic [REM_W-1:0]  rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  side_t             side_r [1:ROOT_W];

  logic [SUM_W-1:0]  a_n    [0:ROOT_W-1];
  logic [REM_W-1:0]  a_rem  [0:ROOT_W-1];
  logic [ROOT_W-1:0] a_root [0:ROOT_W-1];
  side_t             a_side [0:ROOT_W-1];
  sq_step_t          nx     [0:ROOT_W-1];

  always_comb begin
    a_n[0]    = sum;
    a_rem[0]  = '0;
    a_root[0] = '0;
    a_side[0] = in_side;
    for (int s = 1; s < ROOT_W; s++) begin
      a_n[s]    = n_r[s];
      a_rem[s]  = rem_r[s];
      a_root[s] = root_r[s];
      a_side[s] = side_r[s];
    end
    for (int s = 0; s < ROOT_W; s++) begin
      nx[s] = sqrt_step(a_rem[s], a_root[s], a_n[s][SUM_W-1 -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ROOT_W; s++) begin
        n_r[s+1]    <= a_n[s] << 2;
        rem_r[s+1]  <= nx[s].rem;
        root_r[s+1] <= nx[s].root;
        side_r[s+1] <= a_side[s];
      end
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign root      = root_r[ROOT_W];
  assign rem       = rem_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

FILE: hdl/spq_div.sv
module spq_div import spq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [ROOT_W-1:0]       root,
  input  logic [REM_W-1:0]        rem,
  input  side_t                   side,
  input  logic [RAD_W-1:0]        radius,
  input  logic [TOL_W-1:0]        tolerance,
  output logic                    out_valid,
  output logic [2:0][QUO_W-1:0]   quo,
  output logic [2:0]              neg,
  output flags_t                  flags
);

  logic                   va;
  logic                   vb;
  logic [ROOT_W-1:0]      dist_a;
  logic [2:0][PROD_W-1:0] prod_a;
  logic [2:0]             neg_a;
  flags_t                 flags_a;
  logic [ROOT_W-1:0]      dist_b;
  logic [2:0][NUM_W-1:0]  num_b;
  logic [2:0]             neg_b;
  flags_t                 flags_b;

  logic [QUO_W:1]         v_r;
  logic [ROOT_W-1:0]      dd_r [1:QUO_W];
  logic [2:0][NUM_W-1:0]  rr_r [1:QUO_W];
  logic [2:0][QUO_W-1:0]  qq_r [1:QUO_W];
  logic [2:0]             ng_r [1:QUO_W];
  flags_t                 fl_r [1:QUO_W];

  logic [ROOT_W-1:0]      dist_c;
  logic signed [ROOT_W:0] sd_c;
  logic [ROOT_W:0]        sd_mag;
  logic [2:0][PROD_W-1:0] prod_c;
  flags_t                 flags_c;

  logic [ROOT_W-1:0]      a_dd [0:QUO_W-1];
  logic [2:0][NUM_W-1:0]  a_rr [0:QUO_W-1];
  logic [2:0][QUO_W-1:0]  a_qq [0:QUO_W-1];
  logic [2:0][NUM_W-1:0]  n_rr [0:QUO_W-1];
  logic [2:0][QUO_W-1:0]  n_qq [0:QUO_W-1];
  logic [NUM_W-1:0]       sub  [0:QUO_W-1];

  // rounded distance, classification flags, offset times radius
  always_comb begin
    dist_c = root + ROOT_W'(rem > REM_W'(root));
    sd_c   = $signed({1'b0, dist_c}) - $signed((ROOT_W+1)'(radius));
    sd_mag = sd_c[ROOT_W] ? (ROOT_W+1)'(-sd_c) : (ROOT_W+1)'(sd_c);
    flags_c.overlaps   = (ROOT_W+1)'(dist_c) < ((ROOT_W+1)'(radius) + (ROOT_W+1)'(side.orad));
    flags_c.outside    = dist_c > ROOT_W'(radius);
    flags_c.on_shell   = sd_mag < (ROOT_W+1)'(tolerance);
    flags_c.degenerate = side.degen;
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = side.mag[i] * radius;
    end
  end

  // one quotient bit per stage, restoring
  always_comb begin
    a_dd[0] = dist_b;
    a_rr[0] = num_b;
    a_qq[0] = '0;
    for (int s = 1; s < QUO_W; s++) begin
      a_dd[s] = dd_r[s];
      a_rr[s] = rr_r[s];
      a_qq[s] = qq_r[s];
    end
    for (int s = 0; s < QUO_W; s++) begin
      sub[s] = NUM_W'(a_dd[s]) << (QUO_W - 1 - s);
      for (int i = 0; i < 3; i++) begin
        if (a_rr[s][i] >= sub[s]) begin
          n_rr[s][i] = a_rr[s][i] - sub[s];
          n_qq[s][i] = {a_qq[s][i][QUO_W-2:0], 1'b1};
        end else begin
          n_rr[s][i] = a_rr[s][i];
          n_qq[s][i] = {a_qq[s][i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb  <= 1'b0;
      v_r <= '0;
    end else if (en) begin
      va  <= in_valid;
      vb  <= va;
      v_r <= {v_r[QUO_W-1:1], vb};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_a  <= dist_c;
      prod_a  <= prod_c;
      neg_a   <= side.neg;
      flags_a <= flags_c;
      dist_b  <= dist_a;
      neg_b   <= neg_a;
      flags_b <= flags_a;
      for (int i = 0; i < 3; i++) begin
        num_b[i] <= NUM_W'(prod_a[i]) + NUM_W'(dist_a >> 1);
      end
      for (int s = 0; s < QUO_W; s++) begin
        dd_r[s+1] <= a_dd[s];
        rr_r[s+1] <= n_rr[s];
        qq_r[s+1] <= n_qq[s];
      end
      ng_r[1] <= neg_b;
      fl_r[1] <= flags_b;
      for (int s = 1; s < QUO_W; s++) begin
        ng_r[s+1] <= ng_r[s];
        fl_r[s+1] <= fl_r[s];
      end
    end
  end

  assign out_valid = v_r[QUO_W];
  assign quo       = qq_r[QUO_W];
  assign neg       = ng_r[QUO_W];
  assign flags     = fl_r[QUO_W];

endmodule

FILE: sim/tb_top.sv
module tb_top import spq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 57;
  localparam int N_RANDOM       = 650;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  query_valid = 1'b0;
  logic                  query_stall;
  query_t                query = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b1;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sphere_point_query_core u_dut (
    .clk, .rst, .query_valid, .query_stall, .query, .result_valid, .result_stall,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // shadow copy of the sphere registers
  logic signed [COORD_W-1:0] sh_cx, sh_cy, sh_cz;
  logic [RAD_W-1:0]          sh_rad;
  logic [TOL_W-1:0]          sh_tol;

  result_t pending_results[$];
  int      n_mismatch = 0;
  int      n_checked = 0;
  int      idle_cycles = 0;
  int      n_degen = 0;
  int      rx_wait = 0;
  bit      hold_off = 1'b0;

  // rounded integer square root of a 128-bit sum (root fits well under 2^35)
  function automatic longint unsigned round_root(input logic [127:0] n);
    logic [127:0] r, cand;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= n) r = cand;
    end
    if (n - r * r > r) r = r + 1;
    return r[63:0];
  endfunction

  // one coordinate of the nearest surface point, clamped
  function automatic logic signed [COORD_W-1:0] surface_coord(
      input longint c, input longint d, input longint unsigned dlen);
    longint unsigned m, q;
    longint v, hi, lo;
    m  = (d < 0) ? -d : d;
    q  = (m * sh_rad + dlen / 2) / dlen;
    v  = (d < 0) ? c - longint'(q) : c + longint'(q);
    hi = (longint'(1) << (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_W-1:0];
  endfunction

  function automatic result_t classify_point(input query_t q);
    result_t r;
    longint c[3], d[3], sd;
    logic [127:0] sq;
    longint unsigned dlen, m;
    c[0] = sh_cx; c[1] = sh_cy; c[2] = sh_cz;
    d[0] = longint'(q.point_x) - c[0];
    d[1] = longint'(q.point_y) - c[1];
    d[2] = longint'(q.point_z) - c[2];
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m  = (d[i] < 0) ? -d[i] : d[i];
      sq = sq + 128'(m) * 128'(m);
    end
    dlen = round_root(sq);
    sd   = longint'(dlen) - longint'(sh_rad);
    r.overlaps   = dlen < (64'(sh_rad) + 64'(q.other_radius));
    r.outside    = dlen > sh_rad;
    r.on_shell   = ((sd < 0) ? -sd : sd) < longint'(sh_tol);
    r.degenerate = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
    if (r.degenerate || dlen == 0) begin
      r.closest_x = sh_cx; r.closest_y = sh_cy; r.closest_z = sh_cz;
    end else begin
      r.closest_x = surface_coord(c[0], d[0], dlen);
      r.closest_y = surface_coord(c[1], d[1], dlen);
      r.closest_z = surface_coord(c[2], d[2], dlen);
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X:  sh_cx  = val;
      CFG_CENTER_Y:  sh_cy  = val;
      CFG_CENTER_Z:  sh_cz  = val;
      CFG_RADIUS:    sh_rad = val[RAD_W-1:0];
      CFG_TOLERANCE: sh_tol = val[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_sphere(input logic [23:0] cx, cy, cz, input logic [22:0] rad,
                              input logic [11:0] tol);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, 24'(rad));
    write_reg(CFG_TOLERANCE, 24'(tol));
    cfg_valid <= 1'b0;
  endtask

  // offer one query word with a random gap before it
  task automatic send_query(input query_t q, input bit has_ref, input result_t ref_r);
    int gap;
    result_t e;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1'b1;
    query       <= q;
    do @(posedge clk); while (query_stall);
    e = classify_point(q);
    if (has_ref) begin
      // typed-in expectation must agree with the predictor too
      if (ref_r !== e) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("table row disagrees: typed %h predicted %h", ref_r, e);
      end
    end
    if (e.degenerate) n_degen++;
    pending_results.push_back(e);
  endtask

  task automatic drain;
    query_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord(input int mode);
    case (mode)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 16384)) - 24'd8192;
      default: return 24'($urandom);
    endcase
  endfunction

  // directed stimulus table
  typedef struct {
    query_t  q;
    bit      has_ref;
    result_t r;
  } row_t;

  // receiver: a drawn wait after every word, plus one long hold-off
  always @(posedge clk) begin
    int w;
    if (rst) begin
      result_stall <= 1'b1;
      rx_wait      <= 0;
    end else if (hold_off) begin
      result_stall <= 1'b1;
    end else if (result_stall) begin
      if (rx_wait > 1) begin
        rx_wait <= rx_wait - 1;
      end else begin
        result_stall <= 1'b0;
        rx_wait      <= 0;
      end
    end else if (result_valid) begin
      w = $urandom_range(0, 18);
      if ($urandom_range(0, 2) == 0) w = 0;
      if (w != 0) begin
        result_stall <= 1'b1;
        rx_wait      <= w;
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word %h", result);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (result.overlaps !== e.overlaps || result.outside !== e.outside ||
            result.on_shell !== e.on_shell || result.degenerate !== e.degenerate ||
            result.closest_x !== e.closest_x || result.closest_y !== e.closest_y ||
            result.closest_z !== e.closest_z) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result mismatch: expected %h actual %h", e, result);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all, outside the hold-off
  always @(posedge clk) begin
    if ((query_valid && !query_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t    rows[$];
    row_t    rw;
    query_t  q;
    result_t r;
    int      mode;
    sh_cx = '0; sh_cy = '0; sh_cz = '0;
    sh_rad = RADIUS_RESET;
    sh_tol = TOL_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: unit sphere at origin
    // point at center, degenerate
    rw.q = '{0, 0, 0, 0}; rw.has_ref = 1;
    rw.r = '{1, 0, 0, 1, 0, 0, 0}; rows.push_back(rw);
    // point exactly on the surface along x
    rw.q = '{24'd4096, 0, 0, 0}; rw.has_ref = 1;
    rw.r = '{0, 0, 1, 0, 24'd4096, 0, 0}; rows.push_back(rw);
    // far negative z, projects to -1.0
    rw.q = '{0, 0, -24'sd40960, 0}; rw.has_ref = 1;
    rw.r = '{0, 1, 0, 0, 0, 0, -24'sd4096}; rows.push_back(rw);
    // extremes and bit patterns of each field, predictor only
    rw.has_ref = 0;
    rw.q = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF}; rows.push_back(rw);
    rw.q = '{24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF}; rows.push_back(rw);
    rw.q = '{24'h7FFFFF, 24'h800000, 24'h000001, 23'd0}; rows.push_back(rw);
    rw.q = '{24'd2048, 24'd2048, 0, 23'd2048}; rows.push_back(rw);
    rw.q = '{24'd1, 0, 0, 23'd1}; rows.push_back(rw);
    rw.q = '{24'hFFFFFF, 24'h555555, 24'hAAAAAA, 23'h2AAAAA}; rows.push_back(rw);
    rw.q = '{24'h000000, 24'hAAAAAA, 24'h555555, 23'h555555}; rows.push_back(rw);
    foreach (rows[i]) send_query(rows[i].q, rows[i].has_ref, rows[i].r);
    drain();

    // zero tolerance, huge radius, corner center: saturation and no on-surface
    write_sphere(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 12'd0);
    send_query('{24'h800000, 24'h7FFFFF, 24'h800000, 0}, 0, r);
    send_query('{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0}, 0, r);
    send_query('{0, 0, 0, 23'h7FFFFF}, 0, r);
    drain();
    // radius zero and max tolerance
    write_sphere(24'd100, -24'sd100, 24'd7, 23'd0, 12'd4095);
    send_query('{24'd100, -24'sd100, 24'd7, 0}, 0, r);
    send_query('{24'd900, 24'd5, -24'sd3000, 23'd9}, 0, r);
    drain();

    // random phases, each with its own sphere
    for (int ph = 0; ph < 5; ph++) begin
      write_sphere(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                   rand_coord($urandom_range(0, 3)),
                   (ph == 4) ? 23'h7FFFFF : 23'($urandom_range(1, 20000)),
                   12'($urandom_range(0, 4095)));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps pushing
        fork
          begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        mode = $urandom_range(0, 9);
        q.point_x = (mode == 0) ? sh_cx : sh_cx + rand_coord(mode < 5 ? 2 : $urandom_range(0, 3));
        q.point_y = (mode == 0) ? sh_cy : sh_cy + rand_coord(mode < 5 ? 2 : $urandom_range(0, 3));
        q.point_z = (mode == 0) ? sh_cz : sh_cz + rand_coord(mode < 5 ? 2 : $urandom_range(0, 3));
        q.other_radius = ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom);
        if (mode == 1) q.other_radius = 23'($urandom_range(0, 8192));
        send_query(q, 0, r);
      end
      drain();
    end

    $display("checked %0d result words over 8 sphere settings, %0d at the center",
             n_checked, n_degen);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
